[sv/etx_neighbor_link_table_macros.svh]
// Assertion macros for the neighbor link table checker.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ETX_NEIGHBOR_LINK_TABLE_MACROS_SVH
`define ETX_NEIGHBOR_LINK_TABLE_MACROS_SVH

// Same-cycle implication.
`define ETX_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define ETX_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

[sv/etx_pkg.sv]
// Shared types and constants of the neighbor link table.
// No dependencies; used by every module of the block.
package etx_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned WINDOW_SLOTS_DEF  = 12;

  // Widths settled by the field ranges and the parameter ranges.
  localparam int unsigned MAP_W   = 16;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned REV_W   = 8;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned D_W     = 12;
  localparam int unsigned DIV_W   = D_W + 1;
  localparam int unsigned NUM_W   = 21;
  localparam int unsigned ETX_W   = 32;

  localparam logic [NUM_W-1:0] METRIC_NUM      = NUM_W'(2000000);
  localparam logic [ETX_W-1:0] METRIC_INFINITE = '1;

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_REPORT = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_UPDATE,
    CELL_TICK,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_QMUL,
    S_QDIV,
    S_REPORT,
    S_RFIN
  } state_e;

  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] neighbor_address;
    logic [7:0]        probe_slot;
    logic [REV_W-1:0]  reverse_count;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [ETX_W-1:0]  etx_value;
    logic [ADDR_W-1:0] report_address;
    logic [CNT_W-1:0]  report_count;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [MAP_W-1:0]  map;
    logic [REV_W-1:0]  rev;
  } entry_t;

  typedef struct packed {
    cell_op_e          op;
    logic [ADDR_W-1:0] addr;
    logic [MAP_W-1:0]  set_mask;
    logic [REV_W-1:0]  rev;
    logic [MAP_W-1:0]  keep_mask;
    logic [MAP_W-1:0]  win_mask;
  } cell_ctrl_t;

endpackage

[sv/etx_cell.sv]
// One neighbor entry of the sorted table chain.
// Depends on etx_pkg; instantiated in a row by the top level.
module etx_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  etx_pkg::cell_ctrl_t ctrl_i,
  input  etx_pkg::entry_t     left_i,
  input  etx_pkg::entry_t     right_i,
  input  logic                prev_keep_i,
  output etx_pkg::entry_t     ent_o,
  output logic                keep_o,
  output logic                match_o,
  output logic [3:0]          count_o
);
  import etx_pkg::*;

  entry_t ent_q, ent_d;
  logic [MAP_W-1:0] win;

  assign ent_o   = ent_q;
  assign keep_o  = ent_q.valid && (ent_q.addr < ctrl_i.addr);
  assign match_o = ent_q.valid && (ent_q.addr == ctrl_i.addr);
  assign win     = ent_q.map & ctrl_i.win_mask;

  always_comb begin
    count_o = '0;
    for (int j = 0; j < MAP_W; j++) begin
      count_o = count_o + CNT_W'(win[j]);
    end
  end

  always_comb begin
    ent_d = ent_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        // Entries above the new address move up one place to keep the order.
        if (!keep_o) begin
          if (prev_keep_i) begin
            ent_d.valid = 1'b1;
            ent_d.addr  = ctrl_i.addr;
            ent_d.map   = ctrl_i.set_mask;
            ent_d.rev   = ctrl_i.rev;
          end else begin
            ent_d = left_i;
          end
        end
      end
      CELL_UPDATE: begin
        if (match_o) begin
          ent_d.map = ent_q.map | ctrl_i.set_mask;
          ent_d.rev = ctrl_i.rev;
        end
      end
      CELL_TICK:   ent_d.map = ent_q.map & ctrl_i.keep_mask;
      CELL_ROTATE: ent_d = right_i;
      default:     ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

[sv/etx_div.sv]
// Restoring divider for the rounded metric, one quotient bit per cycle.
// Depends on etx_pkg; computes (2000000 + d) / (2 * d).
module etx_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [etx_pkg::D_W-1:0] d_i,
  output logic                    busy_o,
  output logic [etx_pkg::NUM_W-1:0] quo_o
);
  import etx_pkg::*;

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic [DIV_W-1:0]  rem_q, div_q;
  logic [NUM_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [DIV_W:0]    shifted, diff;
  logic              ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};
  assign busy_o  = busy_q;
  assign quo_o   = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(NUM_W);
    end else if (busy_q) begin
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= {d_i, 1'b0};
      quo_q <= METRIC_NUM + NUM_W'(d_i);
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

endmodule

[sv/etx_neighbor_link_table.sv]
// Channel  | Handshake             | Word
// in       | in_valid_i/in_stall_o | etx_pkg::in_word_t (action, address, slot, reverse)
// out      | out_valid_o/out_stall_i | etx_pkg::out_word_t (ok, etx, address, count, last)
// A query of a stored entry runs the bit-serial divider (one quotient bit per
// cycle) before its result word. A report rotates the cell chain once and then
// issues a final word. An output stall holds the sequencer in place. Reset
// clears all entries and the slot.
// Depends on etx_pkg, etx_cell and etx_div.
module etx_neighbor_link_table #(
  parameter int unsigned TABLE_ENTRIES = etx_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned WINDOW_SLOTS  = etx_pkg::WINDOW_SLOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  etx_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output etx_pkg::out_word_t out_word_o
);
  import etx_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [MAP_W-1:0] SlotMask = MAP_W'((33'd1 << WINDOW_SLOTS) - 33'd1);
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(WINDOW_SLOTS - 1);

  state_e state_q, state_d;
  logic [SLOT_W-1:0] slot_q, slot_d, slot_nx, slot_nn;
  logic [CNT_W-1:0]  qcnt_q, qcnt_d, sel_cnt;
  logic [REV_W-1:0]  qrev_q, qrev_d, sel_rev;
  logic [IDX_W-1:0]  step_q, step_d;
  logic              hold_v_q, hold_v_d;
  logic [ADDR_W-1:0] hold_addr_q, hold_addr_d;
  logic [CNT_W-1:0]  hold_cnt_q, hold_cnt_d;
  logic              inf_q, inf_d;
  out_word_t         out_q, out_d;
  logic              out_v_q, out_load;
  logic              out_free, accept, found, full;
  logic [D_W-1:0]    prod;
  logic              div_start, div_busy;
  logic [NUM_W-1:0]  div_quo;
  logic [MAP_W-1:0]  set_mask;
  cell_ctrl_t        ctrl;

  entry_t            ent   [TABLE_ENTRIES];
  logic              keep  [TABLE_ENTRIES];
  logic              match [TABLE_ENTRIES];
  logic [CNT_W-1:0]  cnt   [TABLE_ENTRIES];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    etx_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (ent[(i + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
      .right_i     (ent[(i + 1) % TABLE_ENTRIES]),
      .prev_keep_i ((i == 0) ? 1'b1 : keep[(i + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
      .ent_o       (ent[i]),
      .keep_o      (keep[i]),
      .match_o     (match[i]),
      .count_o     (cnt[i])
    );
  end

  etx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .d_i     (prod),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  assign out_free   = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = ent[TABLE_ENTRIES-1].valid;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;
  assign prod       = D_W'(qcnt_q) * D_W'(qrev_q);

  assign slot_nx  = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign slot_nn  = (slot_nx == LastSlot) ? '0 : slot_nx + 1'b1;
  assign set_mask = (in_word_i.probe_slot < 8'(WINDOW_SLOTS)) ?
                    (MAP_W'(1) << in_word_i.probe_slot[SLOT_W-1:0]) : '0;

  // The matching cell is unique, so the fields merge by OR.
  always_comb begin
    found   = 1'b0;
    sel_cnt = '0;
    sel_rev = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      found   = found | match[i];
      sel_cnt = sel_cnt | (match[i] ? cnt[i] : '0);
      sel_rev = sel_rev | (match[i] ? ent[i].rev : '0);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_word_i.action == ACT_QUERY && found) begin
          state_d = S_QMUL;
        end else if (accept && in_word_i.action == ACT_REPORT) begin
          state_d = S_REPORT;
        end
      end
      S_QMUL:   state_d = S_QDIV;
      S_QDIV:   if (!div_busy && out_free) state_d = S_IDLE;
      S_REPORT: if (out_free && step_q == IDX_W'(TABLE_ENTRIES - 1)) state_d = S_RFIN;
      S_RFIN:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.addr      = in_word_i.neighbor_address;
    ctrl.set_mask  = set_mask;
    ctrl.rev       = in_word_i.reverse_count;
    ctrl.keep_mask = SlotMask & ~(MAP_W'(1) << slot_nn);
    ctrl.win_mask  = SlotMask & ~(MAP_W'(1) << slot_q) & ~(MAP_W'(1) << slot_nx);
    slot_d      = slot_q;
    qcnt_d      = qcnt_q;
    qrev_d      = qrev_q;
    step_d      = step_q;
    hold_v_d    = hold_v_q;
    hold_addr_d = hold_addr_q;
    hold_cnt_d  = hold_cnt_q;
    inf_d       = inf_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_d       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d.last = 1'b1;
          unique case (in_word_i.action)
            ACT_UPDATE: begin
              out_load = 1'b1;
              out_d.ok = found || !full;
              if (found) begin
                ctrl.op = CELL_UPDATE;
              end else if (!full) begin
                ctrl.op = CELL_INSERT;
              end
            end
            ACT_TICK: begin
              out_load = 1'b1;
              out_d.ok = 1'b1;
              ctrl.op  = CELL_TICK;
              slot_d   = slot_nx;
            end
            ACT_QUERY: begin
              qcnt_d = sel_cnt;
              qrev_d = sel_rev;
              if (!found) begin
                out_load        = 1'b1;
                out_d.etx_value = METRIC_INFINITE;
              end
            end
            ACT_REPORT: begin
              step_d   = '0;
              hold_v_d = 1'b0;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      S_QMUL: begin
        div_start = 1'b1;
        inf_d     = (prod == '0);
      end
      S_QDIV: begin
        if (!div_busy && out_free) begin
          out_load        = 1'b1;
          out_d.ok        = 1'b1;
          out_d.last      = 1'b1;
          out_d.etx_value = inf_q ? METRIC_INFINITE : ETX_W'(div_quo);
        end
      end
      S_REPORT: begin
        // Cell 0 shows each entry in ascending order as the chain rotates.
        // A found entry waits in the hold stage until the next one proves it
        // is not the final word.
        if (out_free) begin
          ctrl.op = CELL_ROTATE;
          step_d  = step_q + 1'b1;
          if (ent[0].valid && cnt[0] != '0) begin
            hold_v_d             = 1'b1;
            hold_addr_d          = ent[0].addr;
            hold_cnt_d           = cnt[0];
            out_load             = hold_v_q;
            out_d.ok             = 1'b1;
            out_d.report_address = hold_addr_q;
            out_d.report_count   = hold_cnt_q;
          end
        end
      end
      S_RFIN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          if (hold_v_q) begin
            out_d.ok             = 1'b1;
            out_d.report_address = hold_addr_q;
            out_d.report_count   = hold_cnt_q;
          end
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      slot_q   <= '0;
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q  <= state_d;
      slot_q   <= slot_d;
      hold_v_q <= hold_v_d;
      step_q   <= step_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qcnt_q      <= qcnt_d;
    qrev_q      <= qrev_d;
    hold_addr_q <= hold_addr_d;
    hold_cnt_q  <= hold_cnt_d;
    inf_q       <= inf_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule

[sv/etx_chk.sv]
// Port checker for the neighbor link table, bound to the top level.
// Depends on etx_pkg and etx_neighbor_link_table_macros.svh.
`include "etx_neighbor_link_table_macros.svh"

module etx_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input etx_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input etx_pkg::out_word_t out_word_o
);
  import etx_pkg::*;

  // A stalled input word must stay offered and unchanged.
  `ETX_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_word_i), "input word changed under stall")

  // A stalled output word must not change.
  `ETX_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "output word changed under stall")

  // Only report entries come without last, and those are always valid entries.
  `ETX_ASSERT(a_mid_report, out_valid_o && !out_word_o.last, out_word_o.ok && out_word_o.etx_value == '0 && out_word_o.report_count != '0, "bad non-final report word")

  // A failed result never names an entry.
  `ETX_ASSERT(a_fail_clean, out_valid_o && !out_word_o.ok, out_word_o.last && out_word_o.report_address == '0 && out_word_o.report_count == '0, "failed word carries entry data")

endmodule

bind etx_neighbor_link_table etx_chk u_etx_chk (.*);
